FILE: src/timecode_step_counter_assert.svh
// Assertion macros for the timecode step counter.
`ifndef TIMECODE_STEP_COUNTER_ASSERT_SVH
`define TIMECODE_STEP_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define TCSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timecode_step_counter: assertion failed");

// Next-cycle implication.
`define TCSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timecode_step_counter: assertion failed");

`endif

FILE: src/tcsc_pkg.sv
`timescale 1ns / 1ps

package tcsc_pkg;

    typedef enum logic [1:0] {
        OP_INC  = 2'd0,
        OP_DEC  = 2'd1,
        OP_LOAD = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_FRAMES_MAX = 2'd0,
        REG_DROP_FRAME = 2'd1,
        REG_FIELD_MODE = 2'd2
    } reg_idx_t;

    localparam logic [15:0] FRAMES_MAX_RESET = 16'd29;

    localparam logic [6:0] SEC_WRAP  = 7'd60;
    localparam logic [6:0] MIN_WRAP  = 7'd60;
    localparam logic [5:0] HOUR_WRAP = 6'd24;
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    // floor(x / 30) = (x * DIV30_RECIP) >> DIV30_SHIFT, exact for 16-bit x
    localparam logic [15:0] DIV30_RECIP = 16'd34953;
    localparam int          DIV30_SHIFT = 20;

    function automatic logic is_tenth(input logic [6:0] v);
        return (v == 7'd0)  || (v == 7'd10) || (v == 7'd20) || (v == 7'd30) ||
               (v == 7'd40) || (v == 7'd50) || (v == 7'd60) || (v == 7'd70) ||
               (v == 7'd80) || (v == 7'd90) || (v == 7'd100) || (v == 7'd110) ||
               (v == 7'd120);
    endfunction

endpackage

FILE: src/timecode_step_counter.sv
// An accepted beat enters the input register, then the result register (m_axis_tvalid).
// Throughput: one beat per cycle; the step logic sits between the input register and
// the result register, and s_axis_tready only drops while both hold a beat and
// m_axis_tready is low.
// Reset (aresetn low, synchronous): timecode and field flag clear to zero,
// frames_max returns to 29, drop_frame and field_mode to 0, both stages empty.
`timescale 1ns / 1ps
`include "timecode_step_counter_assert.svh"

module timecode_step_counter #(
    parameter int FRAME_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // load_hours, load_minutes, load_seconds, load_frames, load_field, zero pad
    input  logic [((18 + FRAME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // hours, minutes, seconds, frames, second_field, zero pad
    output logic [((18 + FRAME_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int TD_W  = ((18 + FRAME_BITS + 7) / 8) * 8;
    localparam int CW    = (FRAME_BITS > 16 ? FRAME_BITS : 16) + 1;
    localparam int FR_LO = 17;
    localparam int FR_HI = 16 + FRAME_BITS;
    localparam int FL_B  = 17 + FRAME_BITS;

    logic [15:0]           frames_max_reg;
    logic                  drop_frame_reg;
    logic                  field_mode_reg;
    logic [FRAME_BITS-1:0] drop_start_reg;
    logic [FRAME_BITS-1:0] drop_start_next;
    logic [31:0]           div_prod;
    logic [11:0]           div_q;
    logic [12:0]           drop13;
    logic [CW-1:0]         drop_ext;

    logic                  item_valid_reg;
    tcsc_pkg::op_t         item_op_reg;
    logic [4:0]            item_hours_reg;
    logic [5:0]            item_minutes_reg;
    logic [5:0]            item_seconds_reg;
    logic [FRAME_BITS-1:0] item_frames_reg;
    logic                  item_field_reg;

    logic                  out_valid_reg;
    logic [TD_W-1:0]       out_data_reg;
    logic [TD_W-1:0]       out_data_next;

    logic [4:0]            hour_count_reg,   hour_count_next;
    logic [5:0]            minute_count_reg, minute_count_next;
    logic [5:0]            second_count_reg, second_count_next;
    logic [FRAME_BITS-1:0] frame_count_reg,  frame_count_next;
    logic                  field_flag_reg,   field_flag_next;

    logic                  cfg_wr;
    logic                  accept;
    logic                  advance;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_max_reg <= tcsc_pkg::FRAMES_MAX_RESET;
            drop_frame_reg <= 1'b0;
            field_mode_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (tcsc_pkg::reg_idx_t'(paddr[3:2]))
                tcsc_pkg::REG_FRAMES_MAX: frames_max_reg <= pwdata[15:0];
                tcsc_pkg::REG_DROP_FRAME: drop_frame_reg <= pwdata[0];
                tcsc_pkg::REG_FIELD_MODE: field_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (tcsc_pkg::reg_idx_t'(paddr[3:2]))
            tcsc_pkg::REG_FRAMES_MAX: prdata = {16'd0, frames_max_reg};
            tcsc_pkg::REG_DROP_FRAME: prdata = {31'd0, drop_frame_reg};
            tcsc_pkg::REG_FIELD_MODE: prdata = {31'd0, field_mode_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // drop start = 2 * (1 + frames_max / 30), kept to the frame width
    assign div_prod        = 32'(frames_max_reg) * 32'(tcsc_pkg::DIV30_RECIP);
    assign div_q           = div_prod[31:tcsc_pkg::DIV30_SHIFT];
    assign drop13          = {div_q + 12'd1, 1'b0};
    assign drop_ext        = CW'(drop13);
    assign drop_start_next = drop_ext[FRAME_BITS-1:0];

    always_ff @(posedge aclk) begin
        drop_start_reg <= drop_start_next;
    end

    assign advance       = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
        end else if (advance) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_op_reg      <= tcsc_pkg::op_t'(s_axis_tuser);
            item_hours_reg   <= s_axis_tdata[4:0];
            item_minutes_reg <= s_axis_tdata[10:5];
            item_seconds_reg <= s_axis_tdata[16:11];
            item_frames_reg  <= s_axis_tdata[FR_HI:FR_LO];
            item_field_reg   <= s_axis_tdata[FL_B];
        end
    end

    always_comb begin
        logic [CW-1:0]         fm_ext;
        logic [FRAME_BITS-1:0] fm_frame;
        logic [CW-1:0]         f_up;
        logic [6:0]            sec_up;
        logic [6:0]            min_up;
        logic [5:0]            hour_up;
        logic                  borrow;

        fm_ext   = CW'(frames_max_reg);
        fm_frame = fm_ext[FRAME_BITS-1:0];
        f_up     = CW'(frame_count_reg);
        sec_up   = {1'b0, second_count_reg} + 7'd1;
        min_up   = {1'b0, minute_count_reg} + 7'd1;
        hour_up  = {1'b0, hour_count_reg} + 6'd1;
        borrow   = (frame_count_reg == '0) ||
                   (drop_frame_reg && !tcsc_pkg::is_tenth({1'b0, minute_count_reg}) &&
                    second_count_reg == 6'd0 && frame_count_reg <= drop_start_reg);

        hour_count_next   = hour_count_reg;
        minute_count_next = minute_count_reg;
        second_count_next = second_count_reg;
        frame_count_next  = frame_count_reg;
        field_flag_next   = field_flag_reg;

        unique case (item_op_reg)
            tcsc_pkg::OP_INC: begin
                if (field_mode_reg && !field_flag_reg) begin
                    field_flag_next = 1'b1;
                end else begin
                    f_up = f_up + CW'(1);
                    if (field_mode_reg) begin
                        field_flag_next = 1'b0;
                    end
                end
                if (f_up > fm_ext) begin
                    f_up = '0;
                    if (sec_up >= tcsc_pkg::SEC_WRAP) begin
                        second_count_next = 6'd0;
                        if (drop_frame_reg && !tcsc_pkg::is_tenth(min_up)) begin
                            f_up = CW'(drop_start_reg);
                        end
                        if (min_up >= tcsc_pkg::MIN_WRAP) begin
                            minute_count_next = 6'd0;
                            hour_count_next   = (hour_up >= tcsc_pkg::HOUR_WRAP) ?
                                                5'd0 : hour_up[4:0];
                        end else begin
                            minute_count_next = min_up[5:0];
                        end
                    end else begin
                        second_count_next = sec_up[5:0];
                    end
                end
                frame_count_next = f_up[FRAME_BITS-1:0];
            end
            tcsc_pkg::OP_DEC: begin
                if (field_mode_reg && field_flag_reg) begin
                    field_flag_next = 1'b0;
                end else if (!(frames_max_reg == 16'd0 &&
                               (frame_count_reg == '0 || drop_frame_reg))) begin
                    if (field_mode_reg) begin
                        field_flag_next = 1'b1;
                    end
                    if (!borrow) begin
                        frame_count_next = frame_count_reg - FRAME_BITS'(1);
                    end else begin
                        frame_count_next = fm_frame;
                        if (second_count_reg == 6'd0) begin
                            second_count_next = tcsc_pkg::SEC_LAST;
                            if (minute_count_reg == 6'd0) begin
                                minute_count_next = tcsc_pkg::MIN_LAST;
                                hour_count_next   = (hour_count_reg == 5'd0) ?
                                                    tcsc_pkg::HOUR_LAST :
                                                    hour_count_reg - 5'd1;
                            end else begin
                                minute_count_next = minute_count_reg - 6'd1;
                            end
                        end else begin
                            second_count_next = second_count_reg - 6'd1;
                        end
                    end
                end
            end
            tcsc_pkg::OP_LOAD: begin
                hour_count_next   = item_hours_reg;
                minute_count_next = item_minutes_reg;
                second_count_next = item_seconds_reg;
                frame_count_next  = item_frames_reg;
                field_flag_next   = item_field_reg;
            end
            default: ;
        endcase

        out_data_next = TD_W'({field_flag_next, frame_count_next, second_count_next,
                               minute_count_next, hour_count_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_count_reg   <= '0;
            minute_count_reg <= '0;
            second_count_reg <= '0;
            frame_count_reg  <= '0;
            field_flag_reg   <= 1'b0;
        end else if (advance) begin
            hour_count_reg   <= hour_count_next;
            minute_count_reg <= minute_count_next;
            second_count_reg <= second_count_next;
            frame_count_reg  <= frame_count_next;
            field_flag_reg   <= field_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `TCSC_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_axis_tready, item_valid_reg && out_valid_reg && !m_axis_tready)
    `TCSC_ASSERT_NXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `TCSC_ASSERT_NXT(a_field_kept_outside_field_mode, aclk, aresetn, advance && !field_mode_reg && item_op_reg != tcsc_pkg::OP_LOAD, field_flag_reg == $past(field_flag_reg))
    `TCSC_ASSERT_NXT(a_load_takes_hours, aclk, aresetn, advance && item_op_reg == tcsc_pkg::OP_LOAD, hour_count_reg == $past(item_hours_reg))

endmodule

FILE: verif/tb_timecode_step_counter.sv
`timescale 1ns / 1ps

module tb_timecode_step_counter;

    localparam logic [1:0] OP_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [15:0] ff;
        logic        fld;
    } step_t;

    typedef struct packed {
        logic [4:0]  hh;
        logic [5:0]  mm;
        logic [5:0]  ss;
        logic [15:0] ff;
        logic        fld;
    } tc_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    // configuration as the counter sees it, and its position
    int          cfg_fmax = int'(tcsc_pkg::FRAMES_MAX_RESET);
    bit          cfg_drop = 1'b0;
    bit          cfg_field = 1'b0;
    int          tc_h = 0;
    int          tc_m = 0;
    int          tc_s = 0;
    int          tc_f = 0;
    bit          tc_fld = 1'b0;

    step_t       step_queue[$];
    tc_t         expected_timecodes[$];
    step_t       drv_beat;
    step_t       seen_step;
    tc_t         want_tc;
    int          gap_pct = 36;
    int          mismatches = 0;

    timecode_step_counter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 aclk = ~aclk;

    function automatic int drop_value();
        return (2 * (1 + cfg_fmax / 30)) & 16'hFFFF;
    endfunction

    function automatic tc_t next_timecode(input step_t st);
        int  f;
        bit  brw;
        tc_t r;
        case (st.op)
            tcsc_pkg::OP_INC: begin
                f = tc_f;
                if (cfg_field) begin
                    if (tc_fld) begin
                        f++;
                        tc_fld = 1'b0;
                    end else begin
                        tc_fld = 1'b1;
                    end
                end else begin
                    f++;
                end
                if (f > cfg_fmax) begin
                    f = 0;
                    tc_s++;
                    if (tc_s >= tcsc_pkg::SEC_WRAP) begin
                        tc_s = 0;
                        tc_m++;
                        if (cfg_drop && (tc_m % 10) != 0)
                            f = drop_value();
                        if (tc_m >= tcsc_pkg::MIN_WRAP) begin
                            tc_m = 0;
                            tc_h++;
                            if (tc_h >= tcsc_pkg::HOUR_WRAP)
                                tc_h = 0;
                        end
                    end
                end
                tc_f = f & 16'hFFFF;
            end
            tcsc_pkg::OP_DEC: begin
                if (cfg_field && tc_fld) begin
                    tc_fld = 1'b0;
                end else if (!(cfg_fmax == 0 && (tc_f == 0 || cfg_drop))) begin
                    if (cfg_field)
                        tc_fld = 1'b1;
                    brw = (tc_f == 0) || (cfg_drop && (tc_m % 10) != 0 && tc_s == 0 &&
                                          tc_f <= drop_value());
                    if (!brw) begin
                        tc_f = tc_f - 1;
                    end else begin
                        tc_f = cfg_fmax;
                        if (tc_s == 0) begin
                            tc_s = tcsc_pkg::SEC_LAST;
                            if (tc_m == 0) begin
                                tc_m = tcsc_pkg::MIN_LAST;
                                tc_h = (tc_h == 0) ? tcsc_pkg::HOUR_LAST : tc_h - 1;
                            end else begin
                                tc_m--;
                            end
                        end else begin
                            tc_s--;
                        end
                    end
                end
            end
            tcsc_pkg::OP_LOAD: begin
                tc_h = st.hh;
                tc_m = st.mm;
                tc_s = st.ss;
                tc_f = st.ff;
                tc_fld = st.fld;
            end
            default: ;
        endcase
        r.hh = 5'(tc_h);
        r.mm = 6'(tc_m);
        r.ss = 6'(tc_s);
        r.ff = 16'(tc_f);
        r.fld = tc_fld;
        return r;
    endfunction

    function automatic step_t load_step(input int h, input int m, input int s, input int f,
                                        input bit fld);
        step_t st;
        st.op = tcsc_pkg::OP_LOAD;
        st.hh = 5'(h);
        st.mm = 6'(m);
        st.ss = 6'(s);
        st.ff = 16'(f);
        st.fld = fld;
        return st;
    endfunction

    function automatic step_t op_step(input logic [1:0] op);
        step_t st;
        st = '0;
        st.op = op;
        return st;
    endfunction

    function automatic step_t rand_step();
        step_t st;
        int    r;
        r = $urandom_range(99);
        st.op = (r < 45) ? tcsc_pkg::OP_INC : (r < 80) ? tcsc_pkg::OP_DEC :
                (r < 95) ? tcsc_pkg::OP_LOAD : OP_RSVD;
        st.hh = 5'($urandom_range(23));
        st.mm = 6'($urandom_range(59));
        st.ss = 6'($urandom_range(59));
        st.ff = 16'($urandom_range(cfg_fmax));
        st.fld = 1'($urandom_range(1));
        r = $urandom_range(99);
        if (r < 50) begin
            // park next to a carry, a borrow or a drop point
            st.hh = $urandom_range(1) ? tcsc_pkg::HOUR_LAST : 5'd0;
            st.mm = $urandom_range(1) ? 6'(10 * $urandom_range(5) + 9) : 6'($urandom_range(59));
            st.ss = $urandom_range(1) ? tcsc_pkg::SEC_LAST : 6'd0;
            case ($urandom_range(3))
                0: st.ff = '0;
                1: st.ff = 16'(cfg_fmax);
                2: st.ff = 16'(drop_value());
                default: st.ff = 16'(drop_value() + 1);
            endcase
        end else if (r < 65) begin
            {st.hh, st.mm, st.ss, st.ff, st.fld} = {$urandom, $urandom};
        end
        return st;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (step_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
                drv_beat = step_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, drv_beat.fld, drv_beat.ff, drv_beat.ss, drv_beat.mm,
                                 drv_beat.hh};
                s_axis_tuser <= drv_beat.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= gap_pct);
            if (s_axis_tvalid && s_axis_tready) begin
                seen_step.op = s_axis_tuser;
                seen_step.hh = s_axis_tdata[4:0];
                seen_step.mm = s_axis_tdata[10:5];
                seen_step.ss = s_axis_tdata[16:11];
                seen_step.ff = s_axis_tdata[32:17];
                seen_step.fld = s_axis_tdata[33];
                expected_timecodes.push_back(next_timecode(seen_step));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_timecodes.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want_tc = expected_timecodes.pop_front();
                    check_field("hours", want_tc.hh, m_axis_tdata[4:0]);
                    check_field("minutes", want_tc.mm, m_axis_tdata[10:5]);
                    check_field("seconds", want_tc.ss, m_axis_tdata[16:11]);
                    check_field("frames", want_tc.ff, m_axis_tdata[32:17]);
                    check_field("second_field", want_tc.fld, m_axis_tdata[33]);
                end
            end
        end
    end

    task automatic apb_write(input tcsc_pkg::reg_idx_t idx, input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tcsc_pkg::REG_FRAMES_MAX: cfg_fmax = int'(v[15:0]);
            tcsc_pkg::REG_DROP_FRAME: cfg_drop = v[0];
            tcsc_pkg::REG_FIELD_MODE: cfg_field = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (step_queue.size() != 0 || s_axis_tvalid || expected_timecodes.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int fm, input bit drop, input bit fld_mode, input int n);
        apb_write(tcsc_pkg::REG_FRAMES_MAX, 32'(fm));
        apb_write(tcsc_pkg::REG_DROP_FRAME, {31'd0, drop});
        apb_write(tcsc_pkg::REG_FIELD_MODE, {31'd0, fld_mode});
        repeat (n) step_queue.push_back(rand_step());
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // hour wrap both ways, out-of-range load, reserved op, tenth minute
        step_queue.push_back(load_step(23, 59, 59, 29, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        step_queue.push_back(load_step(31, 63, 63, 65535, 1));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(load_step(0, 0, 0, 0, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        step_queue.push_back(op_step(OP_RSVD));
        step_queue.push_back(load_step(10, 9, 59, 29, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(load_step(1, 2, 3, 4, 1));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        wait_idle();

        // drop points, skipped and not
        apb_write(tcsc_pkg::REG_DROP_FRAME, 32'd1);
        step_queue.push_back(load_step(0, 0, 59, 29, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        step_queue.push_back(load_step(0, 9, 59, 29, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        step_queue.push_back(load_step(0, 1, 0, 2, 0));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        wait_idle();

        // fields across a drop point
        apb_write(tcsc_pkg::REG_FRAMES_MAX, 32'd59);
        apb_write(tcsc_pkg::REG_FIELD_MODE, 32'd1);
        step_queue.push_back(load_step(0, 0, 59, 59, 1));
        step_queue.push_back(op_step(tcsc_pkg::OP_INC));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        step_queue.push_back(op_step(tcsc_pkg::OP_DEC));
        wait_idle();

        run_phase(29, 1, 0, 60);
        run_phase(59, 1, 1, 60);
        run_phase(0, 0, 0, 40);
        run_phase(0, 1, 1, 40);
        gap_pct = 0;
        run_phase(24, 0, 0, 60);
        gap_pct = 36;
        run_phase(65535, 0, 1, 40);
        run_phase(65535, 1, 0, 40);
        repeat (3) run_phase(int'($urandom_range(99)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 40);

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_timecodes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
